// ===== src/pfmt_pkg.sv =====
package pfmt_pkg;

    // Request field layout on the input data bus, lowest bit first
    localparam int MODE_W   = 2;
    localparam int FILE_W   = 16;
    localparam int PAGE_W   = 31;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    localparam int MODE_LSB = 0;
    localparam int FILE_LSB = MODE_LSB + MODE_W;
    localparam int PAGE_LSB = FILE_LSB + FILE_W;
    localparam int SLOT_LSB = PAGE_LSB + PAGE_W;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    // Stored entry: {valid, file, page}
    localparam int ENTRY_W = 1 + FILE_W + PAGE_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OCCUPIED  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_SCAN,
        S_RESULT
    } fsm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_req;   // capture the incoming request
        logic    rd_slot;    // read the entry named by the request slot
        logic    rd_first;   // start a scan at entry 0
        logic    rd_next;    // read the entry after the one under check
        logic    wr_en;      // write the table
        logic    wr_set;     // write a valid entry (else write an empty one)
        logic    wr_at_slot; // write at the request slot (else at the scan address)
        logic    clr_step;   // advance the clearing pass
        logic    res_load;   // capture the pending result
        status_t res_status;
        logic    res_frame;  // report the scan address as found frame
        logic    out_load;   // move the pending result to the output register
    } pfmt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        mode_t req_mode;
        logic  slot_oob;   // insert slot lies beyond the table
        logic  ent_valid;  // entry read last cycle is valid
        logic  ent_hit;    // entry read last cycle matches the request pair
        logic  addr_last;  // scan or clear address is the last entry
        logic  out_free;   // output register can take a result this cycle
    } pfmt_sts_t;

endpackage

// ===== src/pfmt_ctrl.sv =====
module pfmt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  pfmt_pkg::pfmt_sts_t   sts,
    output pfmt_pkg::pfmt_cmd_t   cmd
);
    import pfmt_pkg::*;

    fsm_state_t state_reg, state_next;

    // State register; reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.wr_en    = 1'b1;
                cmd.clr_step = 1'b1;
                if (sts.addr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.req_mode)
                    MODE_INSERT: begin
                        if (sts.slot_oob) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_OCCUPIED;
                            state_next     = S_RESULT;
                        end else begin
                            cmd.rd_slot = 1'b1;
                            state_next  = S_INS_CHK;
                        end
                    end
                    MODE_LOOKUP, MODE_REMOVE: begin
                        cmd.rd_first = 1'b1;
                        state_next   = S_SCAN;
                    end
                    default: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            S_INS_CHK: begin
                cmd.res_load = 1'b1;
                if (sts.ent_valid) begin
                    cmd.res_status = ST_OCCUPIED;
                end else begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_set     = 1'b1;
                    cmd.wr_at_slot = 1'b1;
                    cmd.res_status = ST_OK;
                end
                state_next = S_RESULT;
            end
            S_SCAN: begin
                if (sts.ent_hit) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_frame  = (sts.req_mode == MODE_LOOKUP);
                    // drop the matched entry on remove
                    cmd.wr_en      = (sts.req_mode == MODE_REMOVE);
                    state_next     = S_RESULT;
                end else if (sts.addr_last) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_RESULT;
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pfmt_dp.sv =====
module pfmt_dp #(
    parameter int FRAMES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [pfmt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfmt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  pfmt_pkg::pfmt_cmd_t               cmd,
    output pfmt_pkg::pfmt_sts_t               sts
);
    import pfmt_pkg::*;

    localparam int AW = $clog2(FRAMES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAMES - 1);

    // Request registers
    mode_t               req_mode_reg;
    logic [FILE_W-1:0]   req_file_reg;
    logic [PAGE_W-1:0]   req_page_reg;
    logic [SLOT_W-1:0]   req_slot_reg;

    // Scan / clear address and the entry read from it
    logic [AW-1:0]       addr_reg, addr_next;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                rd_en;
    logic [AW-1:0]       slot_addr;
    logic [AW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    // Entry table
    logic [ENTRY_W-1:0]  entry_mem [FRAMES];

    // Pending result and output register
    status_t             res_status_reg;
    logic [SLOT_W-1:0]   res_frame_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                ent_valid;
    logic [FILE_W-1:0]   ent_file;
    logic [PAGE_W-1:0]   ent_page;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_mode_reg <= mode_t'(s_tdata[MODE_LSB +: MODE_W]);
            req_file_reg <= s_tdata[FILE_LSB +: FILE_W];
            req_page_reg <= s_tdata[PAGE_LSB +: PAGE_W];
            req_slot_reg <= s_tdata[SLOT_LSB +: SLOT_W];
        end
    end

    assign slot_addr = AW'(req_slot_reg);

    // Read address select
    always_comb begin
        rd_en = cmd.rd_slot | cmd.rd_first | cmd.rd_next;
        if (cmd.rd_slot) begin
            rd_addr = slot_addr;
        end else if (cmd.rd_first) begin
            rd_addr = '0;
        end else begin
            rd_addr = addr_reg + AW'(1);
        end
    end

    // Address counter: follows the scan, steps the clearing pass
    always_comb begin
        addr_next = addr_reg;
        if (cmd.rd_first) begin
            addr_next = '0;
        end else if (cmd.rd_next || cmd.clr_step) begin
            addr_next = addr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else begin
            addr_reg <= addr_next;
        end
    end

    // Table write and registered read
    assign wr_addr = cmd.wr_at_slot ? slot_addr : addr_reg;
    assign wr_data = {cmd.wr_set, req_file_reg, req_page_reg};

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // Compare the entry under check against the request pair
    assign ent_valid = rd_data_reg[ENTRY_W-1];
    assign ent_file  = rd_data_reg[PAGE_W +: FILE_W];
    assign ent_page  = rd_data_reg[PAGE_W-1:0];

    assign sts.req_mode  = req_mode_reg;
    assign sts.slot_oob  = (32'(req_slot_reg) >= 32'(FRAMES));
    assign sts.ent_valid = ent_valid;
    assign sts.ent_hit   = ent_valid && (ent_file == req_file_reg)
                           && (ent_page == req_page_reg);
    assign sts.addr_last = (addr_reg == LAST_ADDR);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Hold the pending result
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_frame_reg  <= cmd.res_frame ? SLOT_W'(addr_reg) : '0;
        end
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {res_frame_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/page_frame_map_table.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: mode, file_id, page_no, frame_slot
// m_        out  m_tvalid/m_tready  m_tdata: status, found_frame
//
// One request at a time. Insert reads the slot entry, checks it, writes it if
// it is empty, then moves its result to the output register once that is free;
// lookup and remove scan the table, reading one table entry per cycle through
// the single read port, until a match or the last entry. An unused mode or an
// insert slot beyond the table goes straight from decode to the result.
// After reset a clearing pass empties the table; s_tready stays low until it
// ends. A stalled result waits in the output register while the next request
// is accepted.
module page_frame_map_table #(
    parameter int FRAMES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode[1:0], file_id[17:2], page_no[48:18], frame_slot[54:49], zero[55]
    input  logic [pfmt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], found_frame[7:2]
    output logic [pfmt_pkg::M_TDATA_W-1:0]    m_tdata
);
    import pfmt_pkg::*;

    pfmt_cmd_t cmd;
    pfmt_sts_t sts;

    // Sequencer
    pfmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, compare and output register
    pfmt_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Only one request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // A result never overwrites one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // Insert only fills an empty frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.wr_set) |-> (!sts.ent_valid && !sts.slot_oob))
        else $error("insert into an occupied or missing frame");

    // A remove write lands on the entry that just matched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && !cmd.wr_set && !cmd.clr_step) |-> sts.ent_hit)
        else $error("entry cleared without a match");

endmodule

// ===== dv/page_frame_map_table_tb.sv =====
`timescale 1ns / 1ps

module page_frame_map_table_tb;
    import pfmt_pkg::*;

    localparam int FRAMES      = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int RAND_ITEMS  = 2000;
    localparam int POOL_SIZE   = 16;
    localparam int MAX_REPORTS = 10;

    // mode code that the block does not define
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] frame;
    } answer_t;

    // Mirror of the frame table; predicts the answer to each accepted request
    class page_table_mirror;
        bit                entry_valid [FRAMES];
        logic [FILE_W-1:0] entry_file [FRAMES];
        logic [PAGE_W-1:0] entry_page [FRAMES];
        answer_t           answers_due [$];
        int                mismatches;

        function new();
            mismatches = 0;
            foreach (entry_valid[i]) entry_valid[i] = 1'b0;
        endfunction

        // Lowest valid frame holding the pair, or -1
        function int find_frame(logic [FILE_W-1:0] fid, logic [PAGE_W-1:0] page);
            int hit;
            hit = -1;
            for (int i = FRAMES - 1; i >= 0; i--) begin
                if (entry_valid[i] && entry_file[i] == fid && entry_page[i] == page)
                    hit = i;
            end
            return hit;
        endfunction

        // Random empty frame, or -1 when the table is full
        function int pick_free_frame();
            int free_cnt;
            int pick;
            free_cnt = 0;
            foreach (entry_valid[i]) if (!entry_valid[i]) free_cnt++;
            if (free_cnt == 0) return -1;
            pick = $urandom_range(0, free_cnt - 1);
            foreach (entry_valid[i]) begin
                if (!entry_valid[i]) begin
                    if (pick == 0) return i;
                    pick--;
                end
            end
            return -1;
        endfunction

        // Apply an accepted request and queue its answer
        function void note_request(logic [MODE_W-1:0] mode, logic [FILE_W-1:0] fid,
                                   logic [PAGE_W-1:0] page, logic [SLOT_W-1:0] slot);
            answer_t ans;
            int      hit;
            ans.status = ST_NOT_FOUND;
            ans.frame  = '0;
            if (mode == MODE_INSERT) begin
                if (int'(slot) >= FRAMES || entry_valid[slot]) begin
                    ans.status = ST_OCCUPIED;
                end else begin
                    entry_valid[slot] = 1'b1;
                    entry_file[slot]  = fid;
                    entry_page[slot]  = page;
                    ans.status        = ST_OK;
                end
            end else if (mode == MODE_LOOKUP) begin
                hit = find_frame(fid, page);
                if (hit >= 0) begin
                    ans.status = ST_OK;
                    ans.frame  = hit[SLOT_W-1:0];
                end
            end else if (mode == MODE_REMOVE) begin
                hit = find_frame(fid, page);
                if (hit >= 0) begin
                    entry_valid[hit] = 1'b0;
                    ans.status       = ST_OK;
                end
            end
            answers_due.push_back(ans);
        endfunction

        // Compare one accepted answer with the oldest prediction
        function void check_answer(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] frame);
            answer_t want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected answer: status %0d frame %0d", status, frame);
                return;
            end
            want = answers_due.pop_front();
            if (status !== want.status || frame !== want.frame) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("answer mismatch: status exp %0d got %0d, frame exp %0d got %0d",
                             want.status, status, want.frame, frame);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    page_table_mirror  mirror;
    bit                steady = 1'b0;
    int                idle_cycles = 0;
    logic [FILE_W-1:0] pool_file [POOL_SIZE];
    logic [PAGE_W-1:0] pool_page [POOL_SIZE];

    page_frame_map_table #(
        .FRAMES (FRAMES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result side now and then, except in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    // Check every accepted answer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.check_answer(m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: SLOT_W]);
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Drive one request and hold it until accepted
    task automatic send_request(logic [MODE_W-1:0] mode, logic [FILE_W-1:0] fid,
                                logic [PAGE_W-1:0] page, logic [SLOT_W-1:0] slot);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, slot, page, fid, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.note_request(mode, fid, page, slot);
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_file[i] = FILE_W'($urandom);
            pool_page[i] = PAGE_W'($urandom);
            // odd entries share the file of their neighbor: near misses
            if (i % 2 == 1) pool_file[i] = pool_file[i-1];
        end
    endtask

    task automatic send_random_request();
        logic [MODE_W-1:0] mode;
        logic [FILE_W-1:0] fid;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        int                r;
        int                idx;
        int                free_frame;
        r = $urandom_range(0, 99);
        if (r < 40)      mode = MODE_INSERT;
        else if (r < 65) mode = MODE_LOOKUP;
        else if (r < 95) mode = MODE_REMOVE;
        else             mode = MODE_UNUSED;
        if ($urandom_range(0, 99) < 85) begin
            idx  = $urandom_range(0, POOL_SIZE - 1);
            fid  = pool_file[idx];
            page = pool_page[idx];
        end else begin
            fid  = FILE_W'($urandom);
            page = PAGE_W'($urandom);
        end
        slot       = SLOT_W'($urandom);
        free_frame = mirror.pick_free_frame();
        if (mode == MODE_INSERT && free_frame >= 0 && $urandom_range(0, 99) < 75)
            slot = free_frame[SLOT_W-1:0];
        send_request(mode, fid, page, slot);
    endtask

    initial begin
        mirror = new();
        refill_pool();

        // hold reset, then release
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, occupancy, duplicates, removal, unused mode
        send_request(MODE_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_INSERT, 16'h0000, 31'h00000000, 6'd0);
        send_request(MODE_INSERT, 16'hFFFF, 31'h7FFFFFFF, 6'd63);
        send_request(MODE_INSERT, 16'h1234, 31'h00000005, 6'd0);
        send_request(MODE_LOOKUP, 16'h0000, 31'h00000000, 6'd63);
        send_request(MODE_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_INSERT, 16'hFFFF, 31'h7FFFFFFF, 6'd10);
        send_request(MODE_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_REMOVE, 16'hFFFF, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_LOOKUP, 16'hFFFF, 31'h7FFFFFFE, 6'd0);
        send_request(MODE_LOOKUP, 16'hFFFE, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_UNUSED, 16'hFFFF, 31'h7FFFFFFF, 6'd63);
        send_request(MODE_UNUSED, 16'h0000, 31'h00000000, 6'd0);
        send_request(MODE_REMOVE, 16'h0000, 31'h00000000, 6'd0);
        send_request(MODE_REMOVE, 16'h0000, 31'h00000000, 6'd0);
        send_request(MODE_LOOKUP, 16'h0000, 31'h00000000, 6'd0);
        send_request(MODE_INSERT, 16'h0000, 31'h00000000, 6'd0);
        send_request(MODE_INSERT, 16'hAAAA, 31'h2AAAAAAA, 6'd42);
        send_request(MODE_INSERT, 16'h5555, 31'h55555555, 6'd21);
        send_request(MODE_REMOVE, 16'hFFFF, 31'h7FFFFFFF, 6'd0);
        send_request(MODE_INSERT, 16'hFFFF, 31'h7FFFFFFF, 6'd63);
        send_request(MODE_LOOKUP, 16'h5555, 31'h55555555, 6'd0);

        // random traffic over a small pool of pairs, with a steady stretch
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 800 && n < 1200);
            if (n > 0 && n % 500 == 0) refill_pool();
            send_random_request();
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then let any stray answer show up
        while (mirror.pending() != 0) @(posedge aclk);
        repeat (FRAMES + 8) @(posedge aclk);

        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/pfmt_pkg.sv
src/pfmt_ctrl.sv
src/pfmt_dp.sv
src/page_frame_map_table.sv
dv/page_frame_map_table_tb.sv
